FILE: src/spf_pkg.sv
// ----------------------------------------------------------------------------
// spf_pkg: shared types and constants of the servo packet framer
// Packet kinds, frame constants, and the packet descriptor that the front
// end hands to the serializer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spf_pkg;

    localparam int SPF_CMD_W       = 3;
    localparam int SPF_BYTE_W      = 8;
    localparam int SPF_POS_W       = 16;
    localparam int SPF_MAX_BYTES   = 12;
    localparam int SPF_SIZE_W      = 4;
    localparam int SPF_QUEUE_DEPTH = 2;

    localparam logic [SPF_BYTE_W-1:0] SPF_HDR_BYTE   = 8'hFF;
    localparam logic [SPF_BYTE_W-1:0] SPF_CHECK_MASK = 8'hFE;
    localparam logic [SPF_BYTE_W-1:0] SPF_LEN_ONE    = 8'h01;
    localparam logic [SPF_BYTE_W-1:0] SPF_LEN_TWO    = 8'h02;

    localparam logic [SPF_SIZE_W-1:0] SPF_SIZE_BASIC = 4'd7;
    localparam logic [SPF_SIZE_W-1:0] SPF_SIZE_READ  = 4'd9;
    localparam logic [SPF_SIZE_W-1:0] SPF_SIZE_WR1   = 4'd10;
    localparam logic [SPF_SIZE_W-1:0] SPF_SIZE_WR2   = 4'd11;
    localparam logic [SPF_SIZE_W-1:0] SPF_SIZE_JOG   = 4'hC;

    typedef enum logic [SPF_CMD_W-1:0] {
        CMD_BASIC = 3'd0,
        CMD_WR1   = 3'd1,
        CMD_WR2   = 3'd2,
        CMD_READ  = 3'd3,
        CMD_SJOG  = 3'd4,
        CMD_IJOG  = 3'd5
    } t_cmd;

    typedef struct packed {
        logic [SPF_MAX_BYTES-1:0][SPF_BYTE_W-1:0] pkt_bytes;
        logic [SPF_SIZE_W-1:0]                    size;
    } t_packet;

endpackage

FILE: src/spf_req_if.sv
// ----------------------------------------------------------------------------
// spf_req_if: servo command request channel
// Valid/ready channel that carries one framing request per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface spf_req_if;
    logic                                valid;
    logic                                ready;
    logic [spf_pkg::SPF_CMD_W-1:0]       cmd;
    logic [spf_pkg::SPF_BYTE_W-1:0]      servo_id;
    logic [spf_pkg::SPF_BYTE_W-1:0]      opcode;
    logic [spf_pkg::SPF_BYTE_W-1:0]      reg_address;
    logic [spf_pkg::SPF_BYTE_W-1:0]      value_lo;
    logic [spf_pkg::SPF_BYTE_W-1:0]      value_hi;
    logic [spf_pkg::SPF_BYTE_W-1:0]      read_length;
    logic [spf_pkg::SPF_BYTE_W-1:0]      play_time;
    logic [spf_pkg::SPF_POS_W-1:0]       target_position;

    modport source (
        output valid, cmd, servo_id, opcode, reg_address, value_lo, value_hi,
               read_length, play_time, target_position,
        input  ready
    );

    modport sink (
        input  valid, cmd, servo_id, opcode, reg_address, value_lo, value_hi,
               read_length, play_time, target_position,
        output ready
    );
endinterface

FILE: src/spf_byte_if.sv
// ----------------------------------------------------------------------------
// spf_byte_if: packet byte channel
// Valid/ready channel that carries one packet byte and its last flag per
// transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface spf_byte_if;
    logic                           valid;
    logic                           ready;
    logic [spf_pkg::SPF_BYTE_W-1:0] out_byte;
    logic                           last;

    modport source (
        output valid, out_byte, last,
        input  ready
    );

    modport sink (
        input  valid, out_byte, last,
        output ready
    );
endinterface

FILE: src/servo_packet_framer_top.sv
// ----------------------------------------------------------------------------
// servo_packet_framer_top: servo command packet framer
// Each request transaction on i_req of kinds 0 to 5 becomes one packet on
// o_byte: 0xFF, 0xFF, size, id, command, check1, check2 and a kind-specific
// payload, 7 to 12 bytes, one byte per transaction, with last set on the
// final byte. Request kinds 6 and 7 are taken and produce no bytes. A packet
// leaves at one byte per cycle while o_byte.ready stays high, through the
// single output byte register; packets follow one another back to back
// while the queue holds the next one. The frame builder decodes a request and
// computes both check bytes in the cycle it is taken, and a QUEUE_DEPTH-entry
// packet queue lets i_req keep accepting requests while the serializer is
// still sending; i_req.ready drops only when that queue is full. When the
// block is empty, a request passes through a queue entry, the serializer's
// packet register and the output byte register before its first byte appears.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module servo_packet_framer_top #(
    parameter int QUEUE_DEPTH = spf_pkg::SPF_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spf_req_if.sink     i_req,
    spf_byte_if.source  o_byte
);
    import spf_pkg::*;

    // front end to queue
    logic    push;
    logic    q_ready;
    t_packet push_data;

    // queue to serializer
    logic    q_valid;
    logic    pop;
    t_packet q_data;

    // Decode the request, build the frame, drop unused kinds.
    spf_front u_front (
        .i_req     (i_req),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_data    (push_data)
    );

    // Hold built packets until the serializer is free.
    spf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    // Send the packet bytes through the output register.
    spf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_pop     (pop),
        .o_byte    (o_byte)
    );

    // Never write a full queue.
    a_no_overflow: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) push |-> q_ready
    ) else $error("packet queue written while full");

    // Never fetch from an empty queue.
    a_no_underflow: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) pop |-> q_valid
    ) else $error("packet queue read while empty");

    // Unused kinds (codes above the last jog kind) must not produce a packet.
    a_drop_unused: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && (i_req.cmd > CMD_IJOG)) |-> !push
    ) else $error("unused request kind queued");

    // A queued packet always has a legal size.
    a_legal_size: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        q_valid |-> (q_data.size == SPF_SIZE_BASIC || q_data.size == SPF_SIZE_READ ||
                     q_data.size == SPF_SIZE_WR1 || q_data.size == SPF_SIZE_WR2 ||
                     q_data.size == SPF_SIZE_JOG)
    ) else $error("queued packet has an illegal size");

endmodule

FILE: src/spf_front.sv
// ----------------------------------------------------------------------------
// spf_front: request decoder and frame builder
// Accepts requests, drops unused kind codes, lays out the frame bytes and
// computes both check bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spf_front (
    spf_req_if.sink            i_req,
    input  logic               i_q_ready,
    output logic               o_push,
    output spf_pkg::t_packet   o_data
);
    import spf_pkg::*;

    logic                                     kind_ok;
    logic [SPF_MAX_BYTES-1:0][SPF_BYTE_W-1:0] frame;
    logic [SPF_SIZE_W-1:0]                    size;
    logic [SPF_BYTE_W-1:0]                    chk;
    logic [SPF_BYTE_W-1:0]                    pos_lo;
    logic [SPF_BYTE_W-1:0]                    pos_hi;

    assign pos_lo = i_req.target_position[SPF_BYTE_W-1:0];
    assign pos_hi = i_req.target_position[SPF_POS_W-1:SPF_BYTE_W];

    always_comb begin
        kind_ok = 1'b1;
        size    = SPF_SIZE_BASIC;
        frame   = '0;
        frame[0] = SPF_HDR_BYTE;
        frame[1] = SPF_HDR_BYTE;
        frame[3] = i_req.servo_id;
        frame[4] = i_req.opcode;
        unique case (t_cmd'(i_req.cmd))
            CMD_BASIC: begin
                size = SPF_SIZE_BASIC;
            end
            CMD_WR1: begin
                size     = SPF_SIZE_WR1;
                frame[7] = i_req.reg_address;
                frame[8] = SPF_LEN_ONE;
                frame[9] = i_req.value_lo;
            end
            CMD_WR2: begin
                size      = SPF_SIZE_WR2;
                frame[7]  = i_req.reg_address;
                frame[8]  = SPF_LEN_TWO;
                frame[9]  = i_req.value_lo;
                frame[10] = i_req.value_hi;
            end
            CMD_READ: begin
                size     = SPF_SIZE_READ;
                frame[7] = i_req.reg_address;
                frame[8] = i_req.read_length;
            end
            CMD_SJOG: begin
                size      = SPF_SIZE_JOG;
                frame[7]  = i_req.play_time;
                frame[8]  = pos_lo;
                frame[9]  = pos_hi;
                frame[11] = i_req.servo_id;
            end
            CMD_IJOG: begin
                size      = SPF_SIZE_JOG;
                frame[7]  = pos_lo;
                frame[8]  = pos_hi;
                frame[10] = i_req.servo_id;
                frame[11] = i_req.play_time;
            end
            default: begin
                kind_ok = 1'b0;
            end
        endcase
        frame[2] = {{(SPF_BYTE_W-SPF_SIZE_W){1'b0}}, size};

        // unused payload slots are zero, so they drop out of the XOR
        chk = '0;
        for (int i = 2; i < SPF_MAX_BYTES; i++) begin
            if (i != 5 && i != 6) begin
                chk = chk ^ frame[i];
            end
        end
        frame[5] = chk & SPF_CHECK_MASK;
        frame[6] = (~chk) & SPF_CHECK_MASK;
    end

    // unused kinds are still taken, then dropped
    assign i_req.ready     = i_q_ready;
    assign o_push          = i_req.valid && i_q_ready && kind_ok;
    assign o_data.pkt_bytes = frame;
    assign o_data.size      = size;

endmodule

FILE: src/spf_queue.sv
// ----------------------------------------------------------------------------
// spf_queue: packet descriptor queue
// Short FIFO between the frame builder and the serializer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spf_queue #(
    parameter int DEPTH = spf_pkg::SPF_QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  spf_pkg::t_packet   i_data,
    output logic               o_ready,
    input  logic               i_pop,
    output logic               o_valid,
    output spf_pkg::t_packet   o_data
);
    import spf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_packet            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: src/spf_back.sv
// ----------------------------------------------------------------------------
// spf_back: packet serializer
// Walks the current packet one byte per transaction into an output register
// and fetches the next packet as the last byte enters it, or when idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  spf_pkg::t_packet   i_q_data,
    output logic               o_pop,
    spf_byte_if.source         o_byte
);
    import spf_pkg::*;

    logic                    r_busy,      n_busy;
    t_packet                 r_pkt,       n_pkt;
    logic [SPF_SIZE_W-1:0]   r_idx,       n_idx;
    logic                    r_out_valid, n_out_valid;
    logic [SPF_BYTE_W-1:0]   r_out_byte,  n_out_byte;
    logic                    r_out_last,  n_out_last;

    logic                    load_en;
    logic                    cur_last;

    always_comb begin
        load_en  = !r_out_valid || o_byte.ready;
        cur_last = (r_idx == r_pkt.size - 1'b1);
        o_pop    = i_q_valid && (!r_busy || (load_en && cur_last));

        n_busy      = r_busy;
        n_pkt       = r_pkt;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;

        if (load_en) begin
            n_out_valid = r_busy;
            if (r_busy) begin
                n_out_byte = r_pkt.pkt_bytes[r_idx];
                n_out_last = cur_last;
                n_idx      = r_idx + 1'b1;
                if (cur_last) begin
                    n_busy = 1'b0;
                end
            end
        end
        if (o_pop) begin
            n_busy = 1'b1;
            n_pkt  = i_q_data;
            n_idx  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pkt      <= n_pkt;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_byte.valid    = r_out_valid;
    assign o_byte.out_byte = r_out_byte;
    assign o_byte.last     = r_out_last;

endmodule
